// ===== design/tspe_pkg.sv =====
// ----------------------------------------------------------------------------
// tspe_pkg
// Shared types and constants for the transport stream PES payload extractor.
// ----------------------------------------------------------------------------
package tspe_pkg;

  // Packet geometry
  localparam int unsigned PktLen      = 188;
  localparam int unsigned MaxPayload  = PktLen - 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Summary status codes
  localparam logic [3:0] ST_PTS_TAKEN  = 4'd0;
  localparam logic [3:0] ST_OK_NO_PTS  = 4'd1;
  localparam logic [3:0] ST_TOO_BIG    = 4'd2;
  localparam logic [3:0] ST_SHORT      = 4'd3;
  localparam logic [3:0] ST_START_CODE = 4'd4;
  localparam logic [3:0] ST_STREAM_ID  = 4'd5;
  localparam logic [3:0] ST_SCRAMBLED  = 4'd6;
  localparam logic [3:0] ST_MARKER     = 4'd7;
  localparam logic [3:0] ST_HDR_OVERRUN = 4'd8;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_packet;
  } tspe_in_t;

  // Output beat
  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [3:0]  status;
    logic [7:0]  payload_length;
    logic [31:0] pts;
    logic        last;
  } tspe_out_t;

  // Work entry from front to back: an optional payload byte, then an
  // optional summary record.
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data_val;
    logic        has_sum;
    logic [3:0]  sum_status;
    logic [7:0]  sum_length;
    logic [31:0] sum_pts;
  } tspe_entry_t;

endpackage

// ===== design/tspe_front.sv =====
// ----------------------------------------------------------------------------
// tspe_front
// Packet parser: tracks byte position, skips the adaptation field, checks the
// PES header, captures the timestamp and queues per-byte work entries.
// ----------------------------------------------------------------------------
module tspe_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  input  tspe_pkg::tspe_in_t   in_data_i,
  output logic                 in_ready_o,
  input  logic                 full_i,
  output logic                 push_o,
  output tspe_pkg::tspe_entry_t entry_o
);
  import tspe_pkg::*;

  localparam logic [7:0] LastPos = 8'(PktLen - 1);

  function automatic logic forbidden_id(input logic [7:0] b);
    return b == 8'hBC || b == 8'hBD || b == 8'hBE || b == 8'hBF ||
           b == 8'hF0 || b == 8'hF1 || b == 8'hF2 || b == 8'hF3 || b == 8'hFF;
  endfunction

  logic [7:0]  cap_q;
  logic [7:0]  pos_q, pos_d;
  logic [1:0]  ac_q, ac_d;
  logic        us_q, us_d;
  logic [8:0]  poff_q, poff_d;
  logic [8:0]  phl_q, phl_d;
  logic [1:0]  flags_q, flags_d;
  logic [31:0] tsh_q, tsh_d;
  logic [3:0]  st_q, st_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [31:0] kept_q, kept_d;

  logic [7:0]  b;
  logic [7:0]  p;
  logic        active;
  logic        accept;
  logic        decide_now;
  logic [7:0]  plen;
  logic [7:0]  rel;
  logic [7:0]  ts_start;
  logic        emit;
  logic        sum;
  logic [3:0]  sum_st;

  assign b          = in_data_i.data_byte;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Per-byte parse
  always_comb begin
    p       = in_data_i.first_of_packet ? 8'd0 : pos_q;
    active  = p < 8'(PktLen);
    ac_d    = ac_q;
    us_d    = us_q;
    poff_d  = poff_q;
    phl_d   = phl_q;
    flags_d = flags_q;
    tsh_d   = tsh_q;
    st_d    = st_q;
    cnt_d   = cnt_q;
    kept_d  = kept_q;
    emit    = 1'b0;
    rel     = '0;
    ts_start = '0;

    // Header fields of the transport packet
    if (p == 8'd0) begin
      ac_d    = '0;
      us_d    = 1'b0;
      poff_d  = 9'd4;
      phl_d   = '0;
      flags_d = '0;
      tsh_d   = '0;
      st_d    = ST_OK_NO_PTS;
      cnt_d   = '0;
    end else if (p == 8'd1) begin
      us_d = b[6];
    end else if (p == 8'd3) begin
      ac_d = b[5:4];
    end else if (p == 8'd4 && ac_q[1]) begin
      poff_d = 9'(b) + 9'd5;
    end

    plen = (poff_d < 9'(PktLen)) ? 8'(9'(PktLen) - poff_d) : 8'd0;

    // Capacity and minimum length decision
    decide_now = (p == 8'd3 && !b[5]) || (p == 8'd4 && ac_q[1]);
    if (decide_now) begin
      if (plen > cap_q) begin
        st_d = ST_TOO_BIG;
      end else if (us_d) begin
        phl_d = 9'd9;
        if (plen < 8'd10) st_d = ST_SHORT;
      end
    end

    // Payload region: PES header checks, then elementary bytes
    if ({1'b0, p} >= poff_d && st_d < ST_TOO_BIG) begin
      rel = p - poff_d[7:0];
      if (us_d) begin
        if (rel <= 8'd2) begin
          if (b != ((rel == 8'd2) ? 8'd1 : 8'd0)) st_d = ST_START_CODE;
        end else if (rel == 8'd3) begin
          if (forbidden_id(b)) st_d = ST_STREAM_ID;
        end else if (rel == 8'd6) begin
          if (b[5:4] != 2'b00) st_d = ST_SCRAMBLED;
          else if (b[7:6] != 2'b10) st_d = ST_MARKER;
        end else if (rel == 8'd7) begin
          flags_d = b[7:6];
          if (b[7]) begin
            if (plen < 8'd14) st_d = ST_SHORT;
            else if (b[6] && plen < 8'd19) st_d = ST_SHORT;
          end
        end else if (rel == 8'd8) begin
          phl_d = 9'(b) + 9'd9;
        end else if (rel > 8'd8 && flags_d[1]) begin
          ts_start = flags_d[0] ? 8'd14 : 8'd9;
          if (rel >= ts_start && rel <= ts_start + 8'd4) begin
            tsh_d = {tsh_q[23:0], b};
            if (rel == ts_start + 8'd4) begin
              // 33-bit timestamp with markers stripped, low 32 bits kept
              kept_d = {tsh_q[26:25], tsh_q[23:16], tsh_q[15:9], tsh_q[7:0], b[7:1]};
              st_d   = ST_PTS_TAKEN;
            end
          end
        end
      end
      if (st_d < ST_TOO_BIG && {1'b0, rel} >= phl_d) begin
        emit  = 1'b1;
        cnt_d = cnt_q + 8'd1;
      end
    end

    // Summary at the closing byte
    sum    = (p == LastPos);
    sum_st = (st_d < ST_TOO_BIG && us_d && phl_d > {1'b0, plen}) ? ST_HDR_OVERRUN : st_d;

    pos_d = p + 8'd1;
  end

  // Work entry toward the back end
  assign push_o           = accept && active && (emit || sum);
  assign entry_o.has_data = emit;
  assign entry_o.data_val = b;
  assign entry_o.has_sum  = sum;
  assign entry_o.sum_status = sum_st;
  assign entry_o.sum_length = cnt_d;
  assign entry_o.sum_pts    = kept_d;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 8'(MaxPayload);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ac_q    <= '0;
      us_q    <= 1'b0;
      poff_q  <= 9'd4;
      phl_q   <= '0;
      flags_q <= '0;
      tsh_q   <= '0;
      st_q    <= '0;
      cnt_q   <= '0;
      kept_q  <= '0;
    end else if (accept) begin
      if (active) begin
        pos_q   <= pos_d;
        ac_q    <= ac_d;
        us_q    <= us_d;
        poff_q  <= poff_d;
        phl_q   <= phl_d;
        flags_q <= flags_d;
        tsh_q   <= tsh_d;
        st_q    <= st_d;
        cnt_q   <= cnt_d;
        kept_q  <= kept_d;
      end else begin
        pos_q <= p;
      end
    end
  end

  // A payload never carries more than the packet can hold
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 8'(MaxPayload))
    else $error("emitted count beyond payload size");

  // Failed packets close with no elementary bytes
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o.has_sum && entry_o.sum_status >= ST_TOO_BIG &&
     entry_o.sum_status <= ST_MARKER) |-> (entry_o.sum_length == 8'd0))
    else $error("failed packet reports emitted bytes");

endmodule

// ===== design/tspe_queue.sv =====
// ----------------------------------------------------------------------------
// tspe_queue
// Small flip-flop FIFO decoupling the parser from the output sequencer.
// ----------------------------------------------------------------------------
module tspe_queue #(
  parameter int unsigned Depth = tspe_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tspe_pkg::tspe_entry_t entry_i,
  input  logic                  pop_i,
  output tspe_pkg::tspe_entry_t entry_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import tspe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tspe_entry_t       mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign entry_o = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= entry_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

// ===== design/tspe_back.sv =====
// ----------------------------------------------------------------------------
// tspe_back
// Output sequencer: turns each work entry into a payload beat and/or a summary
// beat, one beat per cycle while out_ready_i is high, formatted from a held entry register.
// ----------------------------------------------------------------------------
module tspe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tspe_pkg::tspe_entry_t entry_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tspe_pkg::tspe_out_t   out_data_o
);
  import tspe_pkg::*;

  tspe_entry_t cur_q;
  logic        cur_valid_q;
  logic        data_done_q;

  logic show_data;
  logic fire;
  logic finish;

  assign show_data = cur_q.has_data && !data_done_q;
  assign fire      = cur_valid_q && out_ready_i;
  assign finish    = fire && !(show_data && cur_q.has_sum);
  assign pop_o     = !empty_i && (!cur_valid_q || finish);

  // Beat formatting
  always_comb begin
    if (show_data) begin
      out_data_o.kind           = KIND_PAYLOAD;
      out_data_o.out_byte       = cur_q.data_val;
      out_data_o.status         = '0;
      out_data_o.payload_length = '0;
      out_data_o.pts            = '0;
      out_data_o.last           = 1'b0;
    end else begin
      out_data_o.kind           = KIND_SUMMARY;
      out_data_o.out_byte       = '0;
      out_data_o.status         = cur_q.sum_status;
      out_data_o.payload_length = cur_q.sum_length;
      out_data_o.pts            = cur_q.sum_pts;
      out_data_o.last           = 1'b1;
    end
  end

  assign out_valid_o = cur_valid_q;

  // Entry payload
  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= entry_i;
  end

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      data_done_q <= 1'b0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      data_done_q <= 1'b0;
    end else if (finish) begin
      cur_valid_q <= 1'b0;
    end else if (fire) begin
      data_done_q <= 1'b1;
    end
  end

  // The byte-done flag only marks entries still owing a summary
  a_done_has_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && data_done_q) |-> (cur_q.has_sum && cur_q.has_data))
    else $error("byte marked done on entry without summary");

endmodule

// ===== design/ts_pes_payload_extract_core.sv =====
// A result is stored in the QueueDepth-entry queue, then in the output
// sequencer's entry register. Throughput: one input byte per cycle while the
// queue is not full; the closing byte of a packet may yield a payload beat
// and a summary beat, drained one per cycle while out_ready_i is high.
// Reset: asynchronous, active low; clears parser state, queue and output
// valid, and sets the capacity register to 184.
// ----------------------------------------------------------------------------
// ts_pes_payload_extract_core
// Transport stream PES payload and timestamp extractor, top level.
// ----------------------------------------------------------------------------
module ts_pes_payload_extract_core #(
  parameter int unsigned QueueDepth = tspe_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tspe_pkg::tspe_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tspe_pkg::tspe_out_t out_data_o
);
  import tspe_pkg::*;

  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  tspe_entry_t push_entry;
  tspe_entry_t head_entry;

  // Parser
  tspe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // Decoupling queue
  tspe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  // Output sequencer
  tspe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
